>>> hw/rtl/olc_pkg.sv
`timescale 1ns / 1ps

package olc_pkg;

    localparam int TIMER_BITS = 16;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_TICKS       = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REBROADCAST_MASK = CFG_INDEX_BITS'(1);

    localparam logic [15:0] HOLD_TICKS_RESET = 16'd200;
    localparam logic [7:0]  MASK_RESET       = 8'd1;
    localparam logic [7:0]  MIN_LEVEL_RESET  = 8'd10;
    localparam logic [7:0]  MAX_LEVEL_RESET  = 8'd100;

    // 80% of maximum is (max / 10) * 8; the divide is x * 205 >> 11, exact for 8-bit x
    localparam logic [7:0] DIV10_MULT  = 8'd205;
    localparam int         DIV10_SHIFT = 11;
    localparam int         NEIGH_SHIFT = 3;

    typedef enum logic [2:0] {
        ST_SLEEPING      = 3'd0,
        ST_AWAKE         = 3'd1,
        ST_TRIGGERED     = 3'd2,
        ST_POST          = 3'd3,
        ST_REQUEST       = 3'd4,
        ST_SET_LEVELS    = 3'd5,
        ST_SET_OPERATION = 3'd6,
        ST_IGNORED       = 3'd7
    } status_t;

endpackage

>>> hw/rtl/occupancy_light_level_controller_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// s_       in         s_valid / s_ready     trigger, neighbour message
// m_       out        m_valid / m_ready     light level, status, min, max, above_idle
// cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while m_ready is high; an accepted item is held in the input
// register, then passes through the tick logic into the result register that drives m_valid.
// Reset clears status, hold timer and neighbour mark, and loads default levels and config.
// A stalled m_ fills the input register and then holds s_ready low; cfg_ready is always high.

module occupancy_light_level_controller_core
    import olc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_local_trigger,
    input  logic                      s_msg_valid,
    input  logic [2:0]                s_msg_opcode,
    input  logic [7:0]                s_msg_low_level,
    input  logic [7:0]                s_msg_high_level,
    input  logic [7:0]                s_msg_flags,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_light_level,
    output logic [2:0]                m_broadcast_status,
    output logic [7:0]                m_broadcast_min,
    output logic [7:0]                m_broadcast_max,
    output logic                      m_above_idle,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam logic [31:0] TIMER_TOP = 32'((64'd1 << TIMER_BITS) - 64'd1);

    // configuration
    logic [15:0] hold_ticks_reg;
    logic [7:0]  mask_reg;

    // tick state
    status_t                status_reg, status_next;
    logic [TIMER_BITS-1:0]  timer_reg, timer_next;
    logic                   mark_reg, mark_next;
    logic [7:0]             min_reg, min_next;
    logic [7:0]             max_reg, max_next;

    // input register
    logic       in_valid_reg;
    logic       in_trig_reg;
    logic       in_msg_valid_reg;
    status_t    in_op_reg;
    logic [7:0] in_lo_reg;
    logic [7:0] in_hi_reg;
    logic [7:0] in_flags_reg;

    // result register
    logic       out_valid_reg;
    logic [7:0] out_level_reg, level_next;
    logic       out_above_reg;

    logic                  out_free;
    logic                  advance;
    logic [31:0]           reload_wide;
    logic [TIMER_BITS-1:0] reload;
    logic [15:0]           div_prod;
    logic [7:0]            max_div10;
    logic [7:0]            neigh_level;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || advance;

    assign reload_wide = (32'(hold_ticks_reg) > TIMER_TOP) ? TIMER_TOP : 32'(hold_ticks_reg);
    assign reload      = TIMER_BITS'(reload_wide);

    assign div_prod    = 16'(max_next) * 16'(DIV10_MULT);
    assign max_div10   = 8'(div_prod >> DIV10_SHIFT);
    assign neigh_level = 8'(max_div10 << NEIGH_SHIFT);

    always_comb begin
        status_next = status_reg;
        timer_next  = timer_reg;
        mark_next   = mark_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        level_next  = min_reg;

        if (in_msg_valid_reg) begin
            case (in_op_reg)
                ST_SET_OPERATION: begin
                    if (in_lo_reg == in_hi_reg) begin
                        level_next  = in_lo_reg;
                        status_next = ((in_flags_reg & mask_reg) == mask_reg)
                                      ? ST_SET_OPERATION : ST_AWAKE;
                    end
                end
                ST_REQUEST: begin
                    if (status_reg == ST_SLEEPING || status_reg == ST_AWAKE ||
                        status_reg == ST_REQUEST || status_reg == ST_POST) begin
                        timer_next = reload;
                        mark_next  = 1'b1;
                    end
                end
                ST_SET_LEVELS: begin
                    min_next = in_lo_reg;
                    max_next = in_hi_reg;
                end
                default: ;
            endcase
        end

        if (in_trig_reg) begin
            level_next  = max_next;
            status_next = ST_REQUEST;
            timer_next  = reload;
            mark_next   = 1'b0;
        end else if (timer_next != '0) begin
            timer_next = timer_next - TIMER_BITS'(1);
            if (timer_next == '0) begin
                level_next  = min_next;
                status_next = ST_AWAKE;
            end else begin
                level_next  = mark_next ? neigh_level : max_next;
                status_next = ST_POST;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg <= HOLD_TICKS_RESET;
            mask_reg       <= MASK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HOLD_TICKS:       hold_ticks_reg <= cfg_data;
                CFG_REBROADCAST_MASK: mask_reg       <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_trig_reg      <= s_local_trigger;
            in_msg_valid_reg <= s_msg_valid;
            in_op_reg        <= status_t'(s_msg_opcode);
            in_lo_reg        <= s_msg_low_level;
            in_hi_reg        <= s_msg_high_level;
            in_flags_reg     <= s_msg_flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg    <= ST_SLEEPING;
            timer_reg     <= '0;
            mark_reg      <= 1'b0;
            min_reg       <= MIN_LEVEL_RESET;
            max_reg       <= MAX_LEVEL_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                status_reg <= status_next;
                timer_reg  <= timer_next;
                mark_reg   <= mark_next;
                min_reg    <= min_next;
                max_reg    <= max_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_level_reg <= level_next;
            out_above_reg <= level_next > min_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_light_level      = out_level_reg;
    assign m_broadcast_status = status_reg;
    assign m_broadcast_min    = min_reg;
    assign m_broadcast_max    = max_reg;
    assign m_above_idle       = out_above_reg;

    // post-triggered only while the hold timer still runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        status_reg == ST_POST |-> timer_reg != '0)
        else $error("post-triggered status with expired hold timer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_above_idle == (m_light_level > m_broadcast_min))
        else $error("above_idle disagrees with level and minimum");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_trig_reg |=> m_valid && m_broadcast_status == ST_REQUEST &&
                                   m_light_level == m_broadcast_max)
        else $error("local trigger did not give maximum level");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_trig_reg) &&
                                     $stable(in_lo_reg) && $stable(in_hi_reg))
        else $error("stalled item lost from input register");

endmodule

>>> bench/tb_occupancy_light_level_controller_core.sv
`timescale 1ns / 1ps

module tb_occupancy_light_level_controller_core;
    import olc_pkg::*;

    localparam int NEIGH_NUM   = 8;
    localparam int NEIGH_DEN   = 10;
    localparam int SETTLE_TICKS = 6;
    localparam int DRAIN_GUARD  = 50000;

    typedef struct packed {
        logic       trig;
        logic       mv;
        logic [2:0] op;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] fl;
    } tick_in_t;

    typedef struct packed {
        logic [7:0] level;
        status_t    status;
        logic [7:0] min_level;
        logic [7:0] max_level;
        logic       above;
    } tick_out_t;

    class light_scoreboard;
        status_t     status;
        logic [15:0] timer;
        bit          neighbour;
        logic [7:0]  min_lvl;
        logic [7:0]  max_lvl;
        logic [15:0] hold;
        logic [7:0]  rb_mask;
        tick_out_t   lamp_outputs_q[$];
        int          n_ticks;
        int          n_checked;
        int          n_cfg;
        int          n_errors;

        function new();
            status    = ST_SLEEPING;
            timer     = '0;
            neighbour = 1'b0;
            min_lvl   = MIN_LEVEL_RESET;
            max_lvl   = MAX_LEVEL_RESET;
            hold      = HOLD_TICKS_RESET;
            rb_mask   = MASK_RESET;
            n_ticks   = 0;
            n_checked = 0;
            n_cfg     = 0;
            n_errors  = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
            n_cfg++;
            case (idx)
                CFG_HOLD_TICKS:       hold = d[15:0];
                CFG_REBROADCAST_MASK: rb_mask = d[7:0];
                default: ;
            endcase
        endfunction

        // advance the controller by one tick and queue the lamp output it gives
        function void note_tick(tick_in_t t);
            status_t   nxt;
            logic [7:0] lvl;
            tick_out_t o;
            nxt = status;
            lvl = min_lvl;      // default is the minimum from the start of the tick
            if (t.mv) begin
                if (t.op == ST_SET_OPERATION) begin
                    if (t.lo == t.hi) begin
                        lvl = t.lo;
                        nxt = ((t.fl & rb_mask) == rb_mask) ? ST_SET_OPERATION : ST_AWAKE;
                    end
                end else if (t.op == ST_REQUEST) begin
                    if (status == ST_SLEEPING || status == ST_AWAKE ||
                        status == ST_REQUEST || status == ST_POST) begin
                        timer     = hold;
                        neighbour = 1'b1;
                    end
                end else if (t.op == ST_SET_LEVELS) begin
                    min_lvl = t.lo;
                    max_lvl = t.hi;
                end
            end
            if (t.trig) begin
                lvl       = max_lvl;
                nxt       = ST_REQUEST;
                timer     = hold;
                neighbour = 1'b0;
            end else if (timer != 0) begin
                lvl   = neighbour ? 8'((max_lvl / NEIGH_DEN) * NEIGH_NUM) : max_lvl;
                timer = timer - 16'd1;
                nxt   = ST_POST;
                if (timer == 0) begin
                    lvl = min_lvl;
                    nxt = ST_AWAKE;
                end
            end
            status      = nxt;
            o.level     = lvl;
            o.status    = nxt;
            o.min_level = min_lvl;
            o.max_level = max_lvl;
            o.above     = (lvl > min_lvl);
            lamp_outputs_q.push_back(o);
            n_ticks++;
        endfunction

        function void check_result(tick_out_t g);
            tick_out_t e;
            if (lamp_outputs_q.size() == 0) begin
                $display("%0t: unexpected output, level %0d status %0d", $time, g.level, g.status);
                n_errors++;
                return;
            end
            e = lamp_outputs_q.pop_front();
            n_checked++;
            if (g.level !== e.level) begin
                $display("%0t: light_level expected %0d, got %0d", $time, e.level, g.level);
                n_errors++;
            end
            if (g.status !== e.status) begin
                $display("%0t: broadcast_status expected %0d, got %0d",
                         $time, e.status, g.status);
                n_errors++;
            end
            if (g.min_level !== e.min_level) begin
                $display("%0t: broadcast_min expected %0d, got %0d",
                         $time, e.min_level, g.min_level);
                n_errors++;
            end
            if (g.max_level !== e.max_level) begin
                $display("%0t: broadcast_max expected %0d, got %0d",
                         $time, e.max_level, g.max_level);
                n_errors++;
            end
            if (g.above !== e.above) begin
                $display("%0t: above_idle expected %0d, got %0d", $time, e.above, g.above);
                n_errors++;
            end
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic     s_valid = 1'b0;
    logic     s_ready;
    tick_in_t drv     = '0;

    logic      m_valid;
    logic      m_ready = 1'b0;
    logic [7:0] m_light_level;
    logic [2:0] m_broadcast_status;
    logic [7:0] m_broadcast_min;
    logic [7:0] m_broadcast_max;
    logic       m_above_idle;
    tick_out_t  got;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_phases       = 0;

    light_scoreboard sb = new();

    assign got = {m_light_level, m_broadcast_status, m_broadcast_min,
                  m_broadcast_max, m_above_idle};

    occupancy_light_level_controller_core u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_local_trigger    (drv.trig),
        .s_msg_valid        (drv.mv),
        .s_msg_opcode       (drv.op),
        .s_msg_low_level    (drv.lo),
        .s_msg_high_level   (drv.hi),
        .s_msg_flags        (drv.fl),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_light_level      (m_light_level),
        .m_broadcast_status (m_broadcast_status),
        .m_broadcast_min    (m_broadcast_min),
        .m_broadcast_max    (m_broadcast_max),
        .m_above_idle       (m_above_idle),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                sb.note_tick(drv);
            if (m_valid && m_ready)
                sb.check_result(got);
        end
    end

    function automatic tick_in_t mk(logic trig, logic mv, logic [2:0] op,
                                    logic [7:0] lo, logic [7:0] hi, logic [7:0] fl);
        tick_in_t t;
        t.trig = trig;
        t.mv   = mv;
        t.op   = op;
        t.lo   = lo;
        t.hi   = hi;
        t.fl   = fl;
        return t;
    endfunction

    // mostly requests, level changes and forced levels with random content
    function automatic tick_in_t random_tick();
        tick_in_t t;
        int       pick;
        t.trig = ($urandom_range(99) < 6);
        t.mv   = ($urandom_range(99) < 60);
        t.lo   = 8'($urandom_range(255));
        t.hi   = 8'($urandom_range(255));
        t.fl   = 8'($urandom_range(255));
        pick   = $urandom_range(99);
        if (pick < 30)
            t.op = ST_REQUEST;
        else if (pick < 52)
            t.op = ST_SET_OPERATION;
        else if (pick < 62)
            t.op = ST_SET_LEVELS;
        else
            t.op = 3'($urandom_range(7));
        if (t.op == ST_SET_OPERATION && $urandom_range(1) == 1)
            t.hi = t.lo;
        if ($urandom_range(99) < 40)
            t.fl = t.fl | sb.rb_mask;
        return t;
    endfunction

    // valid is left high after acceptance so back-to-back items need no re-raise
    task automatic send_tick(tick_in_t t);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge aclk);
        end
        s_valid <= 1'b1;
        drv     <= t;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.lamp_outputs_q.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(logic [15:0] hold, logic [7:0] mask);
        wait_drained();
        write_register(CFG_HOLD_TICKS, hold);
        write_register(CFG_REBROADCAST_MASK, 16'(mask));
        n_phases++;
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct,
                             logic [15:0] hold, logic [7:0] mask);
        configure(hold, mask);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n; k++) begin
            if (k == n / 2)
                wait_drained();     // sender holds off until the pipe is empty
            send_tick(random_tick());
        end
    endtask

    initial begin
        #3_000_000;
        $display("tb_occupancy_light_level_controller_core: FAIL");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values of levels, hold and mask
        send_tick(mk(1'b0, 1'b0, ST_SLEEPING, 8'd0, 8'd0, 8'd0));
        send_tick(mk(1'b0, 1'b1, ST_REQUEST, 8'd0, 8'd0, 8'd0));
        send_tick(mk(1'b0, 1'b1, ST_TRIGGERED, 8'd1, 8'd2, 8'd3));
        send_tick(mk(1'b1, 1'b0, ST_SLEEPING, 8'd0, 8'd0, 8'd0));
        send_tick(mk(1'b0, 1'b1, ST_REQUEST, 8'd0, 8'd0, 8'd0));
        // timer running overrides a forced level
        send_tick(mk(1'b0, 1'b1, ST_SET_OPERATION, 8'd200, 8'd200, 8'd1));
        send_tick(mk(1'b0, 1'b1, ST_SET_LEVELS, 8'd0, 8'd255, 8'd0));
        send_tick(mk(1'b1, 1'b1, ST_SET_LEVELS, 8'd255, 8'd0, 8'hFF));
        send_tick(mk(1'b0, 1'b1, ST_SET_OPERATION, 8'd7, 8'd8, 8'hFF));
        send_tick(mk(1'b0, 1'b1, ST_IGNORED, 8'hFF, 8'hFF, 8'hFF));
        send_tick(mk(1'b0, 1'b0, ST_SET_OPERATION, 8'd40, 8'd40, 8'hFF));

        // zero hold and zero mask
        configure(16'd0, 8'd0);
        send_tick(mk(1'b1, 1'b0, ST_SLEEPING, 8'd0, 8'd0, 8'd0));
        send_tick(mk(1'b0, 1'b0, ST_SLEEPING, 8'd0, 8'd0, 8'd0));
        send_tick(mk(1'b0, 1'b1, ST_SET_OPERATION, 8'd50, 8'd50, 8'd0));
        send_tick(mk(1'b0, 1'b1, ST_REQUEST, 8'd0, 8'd0, 8'd0));   // ignored in set operation

        configure(16'd2, 8'hFF);
        send_tick(mk(1'b0, 1'b1, ST_SET_LEVELS, 8'd20, 8'd250, 8'd0));
        send_tick(mk(1'b0, 1'b1, ST_SET_OPERATION, 8'd255, 8'd255, 8'hFE));
        send_tick(mk(1'b0, 1'b1, ST_SET_OPERATION, 8'd0, 8'd0, 8'hFF));
        send_tick(mk(1'b1, 1'b0, ST_SLEEPING, 8'd0, 8'd0, 8'd0));
        send_tick(mk(1'b0, 1'b1, ST_AWAKE, 8'd9, 8'd9, 8'd0));
        send_tick(mk(1'b0, 1'b0, ST_SLEEPING, 8'd0, 8'd0, 8'd0));
        send_tick(mk(1'b0, 1'b1, ST_REQUEST, 8'hAA, 8'h55, 8'h0F));
        send_tick(mk(1'b0, 1'b1, ST_REQUEST, 8'h55, 8'hAA, 8'hF0));
        send_tick(mk(1'b0, 1'b1, ST_POST, 8'd0, 8'd0, 8'd0));
        send_tick(mk(1'b0, 1'b0, ST_SLEEPING, 8'd0, 8'd0, 8'd0));

        run_phase(220, 84, 0, 16'd1, 8'd0);
        run_phase(150, 0, 84, 16'hFFFF, 8'hFF);
        run_phase(220, 26, 26, 16'd4, 8'h81);
        run_phase(250, 0, 0, 16'd9, 8'($urandom_range(255)));
        run_phase(200, 26, 26, 16'($urandom_range(20, 2)), 8'($urandom_range(255)));

        wait_drained();
        if (sb.lamp_outputs_q.size() != 0) begin
            $display("%0t: %0d expected outputs never arrived", $time, sb.lamp_outputs_q.size());
            sb.n_errors++;
        end

        $display("Ran %0d ticks over %0d register settings, %0d register writes.",
                 sb.n_ticks, n_phases + 1, sb.n_cfg);
        $display("Checked %0d lamp outputs, %0d mismatches.", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0)
            $display("tb_occupancy_light_level_controller_core: PASS");
        else
            $display("tb_occupancy_light_level_controller_core: FAIL");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/olc_pkg.sv
hw/rtl/occupancy_light_level_controller_core.sv
bench/tb_occupancy_light_level_controller_core.sv
